// File: hdl/name_directory_table_defines.svh
// Assertion macros for the name directory table RTL.
// Needs signals named clock and reset in the module that uses them.
`ifndef NAME_DIRECTORY_TABLE_DEFINES_SVH
`define NAME_DIRECTORY_TABLE_DEFINES_SVH

// check outside reset
`define NDT_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("name_directory_table: check failed");

// check at every edge, reset included
`define NDT_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("name_directory_table: check failed");

`endif

// File: hdl/ndt_pkg.sv
// Package of the name directory table: sizes, operation codes, entry and RAM port types.
// No dependencies.
`default_nettype none
package ndt_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int NAME_BYTES  = 8;

   localparam int IDX_W    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
   localparam int NAME_W   = 64;
   localparam int SECTOR_W = 10;
   localparam int SLOT_W   = 6;
   localparam int FUNC_W   = 2;

   localparam int ACTIVE_W   = 7;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET       = 7'd10;
   localparam logic                REG_ACTIVE_ENTRIES = 1'b0;

   localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

   typedef struct packed {
      logic [NAME_W-1:0]   name;
      logic [SECTOR_W-1:0] sector;
   } entry_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      entry_type        data;
   } ram_wr_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
   } ram_rd_type;

endpackage
`default_nettype wire

// File: hdl/ndt_channels.sv
// Request and response channel interfaces of the name directory table.
// No dependencies.
`default_nettype none
interface ndt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [63:0] key_name;
   logic [9:0]  new_sector;

   modport source (output valid, output func, output key_name, output new_sector,
                   input ready);
   modport sink   (input valid, input func, input key_name, input new_sector,
                   output ready);
endinterface

interface ndt_rsp_if;
   logic       valid;
   logic       ready;
   logic       success;
   logic [9:0] found_sector;
   logic [5:0] slot_index;

   modport source (output valid, output success, output found_sector,
                   output slot_index, input ready);
   modport sink   (input valid, input success, input found_sector,
                   input slot_index, output ready);
endinterface
`default_nettype wire

// File: hdl/ndt_csr.sv
// APB-style register block holding the active entry count.
// Depends on ndt_pkg.
`default_nettype none
module ndt_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [ndt_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [ndt_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic      [ndt_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                  pready,
   output logic      [ndt_pkg::ACTIVE_W-1:0]     active_entries
);

   logic [ndt_pkg::ACTIVE_W-1:0] active_ff;
   logic [ndt_pkg::ACTIVE_W-1:0] active_in;
   logic                         sel_active;

   assign sel_active     = (paddr[2] == ndt_pkg::REG_ACTIVE_ENTRIES);
   assign pready         = 1'b1;
   assign active_entries = active_ff;

   always_comb begin
      active_in = active_ff;
      if (psel && penable && pwrite && sel_active) begin
         active_in = pwdata[ndt_pkg::ACTIVE_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (sel_active) begin
         prdata = ndt_pkg::CSR_DATA_W'(active_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ndt_pkg::ACTIVE_RESET;
      end else begin
         active_ff <= active_in;
      end
   end

endmodule
`default_nettype wire

// File: hdl/ndt_entry_ram.sv
// Single-port-write, single-port-read entry memory with registered read data.
// Depends on ndt_pkg.
`default_nettype none
module ndt_entry_ram (
   input  wire logic                clock,
   input  wire ndt_pkg::ram_wr_type wr,
   input  wire ndt_pkg::ram_rd_type rd,
   output ndt_pkg::entry_type       rd_data_ff
);

   ndt_pkg::entry_type entry_mem [ndt_pkg::TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         entry_mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= entry_mem[rd.addr];
      end
   end

endmodule
`default_nettype wire

// File: hdl/ndt_ctrl.sv
// Scan sequencer: valid bits, memory scan, find/add/remove decision and result register.
// Depends on ndt_pkg, ndt_channels and name_directory_table_defines.svh.
`default_nettype none
`include "name_directory_table_defines.svh"
module ndt_ctrl (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [ndt_pkg::ACTIVE_W-1:0]   active_entries,
   ndt_req_if.sink                             req,
   ndt_rsp_if.source                           rsp,
   output ndt_pkg::ram_wr_type                 wr,
   output ndt_pkg::ram_rd_type                 rd,
   input  wire ndt_pkg::entry_type             rd_data
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_LAST   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   function automatic logic [ndt_pkg::NAME_W-1:0] normalize(
      input logic [ndt_pkg::NAME_W-1:0] raw);
      logic                         live;
      logic [ndt_pkg::NAME_W-1:0]   kept;
      live = 1'b1;
      kept = '0;
      for (int i = 0; i < ndt_pkg::NAME_BYTES; i++) begin
         if (raw[8*i +: 8] == 8'd0) live = 1'b0;
         if (live) kept[8*i +: 8] = raw[8*i +: 8];
      end
      return kept;
   endfunction

   logic [1:0]                     state_ff, state_in;
   logic [ndt_pkg::TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [ndt_pkg::IDX_W-1:0]      addr_ff, addr_in;
   logic                           pend_ff, pend_in;
   logic [ndt_pkg::IDX_W-1:0]      pend_addr_ff;
   logic                           hit_ff, hit_in;
   logic                           free_ff, free_in;
   logic                           out_valid_ff, out_valid_in;

   logic [ndt_pkg::FUNC_W-1:0]     func_ff;
   logic [ndt_pkg::NAME_W-1:0]     key_ff;
   logic [ndt_pkg::SECTOR_W-1:0]   sector_ff;
   logic [ndt_pkg::CNT_W-1:0]      limit_ff, limit_new;
   logic [ndt_pkg::IDX_W-1:0]      hit_idx_ff, free_idx_ff;
   logic [ndt_pkg::SECTOR_W-1:0]   hit_sector_ff;
   logic                           out_success_ff, res_success;
   logic [ndt_pkg::SECTOR_W-1:0]   out_sector_ff, res_sector;
   logic [ndt_pkg::SLOT_W-1:0]     out_slot_ff, res_slot;

   logic accept, addr_last, entry_match, entry_free, out_free, load;
   logic do_add, do_remove;

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;

   always_comb begin
      if (32'(active_entries) > 32'(ndt_pkg::TABLE_DEPTH)) begin
         limit_new = ndt_pkg::CNT_W'(ndt_pkg::TABLE_DEPTH);
      end else begin
         limit_new = ndt_pkg::CNT_W'(active_entries);
      end
   end

   assign addr_last   = (ndt_pkg::CNT_W'(addr_ff) + ndt_pkg::CNT_W'(1)) == limit_ff;
   assign rd.en       = (state_ff == ST_SCAN);
   assign rd.addr     = addr_ff;
   assign entry_match = pend_ff && valid_ff[pend_addr_ff] && (rd_data.name == key_ff);
   assign entry_free  = pend_ff && !valid_ff[pend_addr_ff];
   assign out_free    = !out_valid_ff || rsp.ready;
   assign load        = (state_ff == ST_FINISH) && out_free;
   assign do_add      = load && (func_ff == ndt_pkg::FUNC_ADD) && !hit_ff && free_ff;
   assign do_remove   = load && (func_ff == ndt_pkg::FUNC_REMOVE) && hit_ff;

   assign wr.en          = do_add;
   assign wr.addr        = free_idx_ff;
   assign wr.data.name   = key_ff;
   assign wr.data.sector = sector_ff;

   always_comb begin
      res_success = 1'b0;
      res_sector  = '0;
      res_slot    = '0;
      case (func_ff)
         ndt_pkg::FUNC_FIND: begin
            if (hit_ff) begin
               res_success = 1'b1;
               res_sector  = hit_sector_ff;
               res_slot    = ndt_pkg::SLOT_W'(hit_idx_ff);
            end
         end
         ndt_pkg::FUNC_ADD: begin
            if (!hit_ff && free_ff) begin
               res_success = 1'b1;
               res_slot    = ndt_pkg::SLOT_W'(free_idx_ff);
            end
         end
         ndt_pkg::FUNC_REMOVE: begin
            if (hit_ff) begin
               res_success = 1'b1;
               res_slot    = ndt_pkg::SLOT_W'(hit_idx_ff);
            end
         end
         default: begin
            res_success = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (limit_new == '0) ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (addr_last) state_in = ST_LAST;
         end
         ST_LAST: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      addr_in = addr_ff;
      if (accept) begin
         addr_in = '0;
      end else if (rd.en) begin
         addr_in = addr_ff + ndt_pkg::IDX_W'(1);
      end
      pend_in = rd.en;
      hit_in  = hit_ff;
      free_in = free_ff;
      if (accept) begin
         hit_in  = 1'b0;
         free_in = 1'b0;
      end else begin
         if (entry_match) hit_in = 1'b1;
         if (entry_free) free_in = 1'b1;
      end
      valid_in = valid_ff;
      if (do_add) valid_in[free_idx_ff] = 1'b1;
      if (do_remove) valid_in[hit_idx_ff] = 1'b0;
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         addr_ff      <= '0;
         pend_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         addr_ff      <= addr_in;
         pend_ff      <= pend_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= addr_ff;
      if (accept) begin
         func_ff   <= req.func;
         key_ff    <= normalize(req.key_name);
         sector_ff <= req.new_sector;
         limit_ff  <= limit_new;
      end
      if (entry_match && !hit_ff && !accept) begin
         hit_idx_ff    <= pend_addr_ff;
         hit_sector_ff <= rd_data.sector;
      end
      if (entry_free && !free_ff && !accept) begin
         free_idx_ff <= pend_addr_ff;
      end
      if (load) begin
         out_success_ff <= res_success;
         out_sector_ff  <= res_sector;
         out_slot_ff    <= res_slot;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.success      = out_success_ff;
   assign rsp.found_sector = out_sector_ff;
   assign rsp.slot_index   = out_slot_ff;

   `NDT_ASSERT(scan_in_range, rd.en |-> (ndt_pkg::CNT_W'(rd.addr) < limit_ff))
   `NDT_ASSERT(no_ram_collision, !(rd.en && wr.en))
   `NDT_ASSERT(add_to_free_slot, wr.en |-> !valid_ff[wr.addr])
   `NDT_ASSERT_ALWAYS(valid_change_on_finish,
      (!reset && !$past(reset) && !$stable(valid_ff)) |-> $past(load))

endmodule
`default_nettype wire

// File: hdl/name_directory_table.sv
// Name directory table top level: register block, entry memory and scan sequencer.
// Depends on ndt_pkg, ndt_channels, ndt_csr, ndt_entry_ram and ndt_ctrl.
//
// Usage:
//   req_chan carries one item: func (find, add, remove), key_name and new_sector.
//   rsp_chan returns exactly one item per request: success, found_sector, slot_index.
//   The APB-style port holds active_entries at byte address 0 (reset value 10).
//   Each request scans n = min(active_entries, table depth) slots, one memory read
//   per cycle, as the entry memory has a single read port; the sequencer passes
//   through its scan, last and finish states before the result is loaded into the
//   output register. With n = 0 the scan is skipped and the request goes straight
//   to the finish state.
//   Requests are taken one at a time; the next is accepted once the result has
//   moved into the output register, which may still be waiting on the receiver.
//   A stalled receiver holds the result; a finished scan waits until it is taken.
//   Reset clears all valid bits in flip-flops at once and restores the register;
//   there is no clearing pass. Names are compared up to their first zero byte.
//
`default_nettype none
module name_directory_table (
   input  wire logic                           clock,
   input  wire logic                           reset,
   ndt_req_if.sink                             req_chan,
   ndt_rsp_if.source                           rsp_chan,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [ndt_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [ndt_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [ndt_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                pready
);

   logic [ndt_pkg::ACTIVE_W-1:0] active_entries;
   ndt_pkg::ram_wr_type          ram_wr;
   ndt_pkg::ram_rd_type          ram_rd;
   ndt_pkg::entry_type           ram_rd_data;

   ndt_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .active_entries (active_entries)
   );

   ndt_entry_ram u_ram (
      .clock      (clock),
      .wr         (ram_wr),
      .rd         (ram_rd),
      .rd_data_ff (ram_rd_data)
   );

   ndt_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .active_entries (active_entries),
      .req            (req_chan),
      .rsp            (rsp_chan),
      .wr             (ram_wr),
      .rd             (ram_rd),
      .rd_data        (ram_rd_data)
   );

endmodule
`default_nettype wire
